@@ hw/rtl/tdsm_pkg.sv @@
// Shared types, codes and glyph tables for the three-digit display multiplexer.
package tdsm_pkg;

  // Field widths
  localparam int VALUE_W    = 10;
  localparam int MODE_W     = 2;
  localparam int DIGIT_W    = 4;
  localparam int REM_W      = 7;
  localparam int SEG_W      = 7;
  localparam int EN_W       = 3;
  localparam int POS_W      = 2;
  localparam int IDX_W      = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Largest number the display can show
  localparam logic [VALUE_W-1:0] MAX_SHOWN = 10'd999;

  // Item kinds carried in tuser
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Display modes
  localparam logic [MODE_W-1:0] MODE_NUMERIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SP1     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SP2     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REC     = 2'd3;

  // Position register codes (zero is never reached and acts as units)
  localparam logic [POS_W-1:0] POS_UNITS    = 2'd1;
  localparam logic [POS_W-1:0] POS_TENS     = 2'd2;
  localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd3;

  // Digit index codes
  localparam logic [IDX_W-1:0] IDX_UNITS    = 2'd0;
  localparam logic [IDX_W-1:0] IDX_TENS     = 2'd1;
  localparam logic [IDX_W-1:0] IDX_HUNDREDS = 2'd2;

  // Active-low segments, all dark
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

  typedef struct packed {
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } digits_t;

  // Map a decimal digit to active-low segments; anything above nine is blank
  function automatic logic [SEG_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 7'h40;
      4'd1:    g = 7'h79;
      4'd2:    g = 7'h24;
      4'd3:    g = 7'h30;
      4'd4:    g = 7'h19;
      4'd5:    g = 7'h12;
      4'd6:    g = 7'h02;
      4'd7:    g = 7'h78;
      4'd8:    g = 7'h00;
      4'd9:    g = 7'h18;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  // Map a word mode and a digit index to a fixed letter or numeral
  function automatic logic [SEG_W-1:0] word_glyph(input logic [MODE_W-1:0] m,
                                                  input logic [IDX_W-1:0]  idx);
    logic [SEG_W-1:0] g;
    g = SEG_BLANK;
    unique case (m)
      MODE_SP1: begin
        unique case (idx)
          IDX_UNITS:    g = 7'h79;
          IDX_TENS:     g = 7'h0C;
          IDX_HUNDREDS: g = 7'h12;
          default:      g = SEG_BLANK;
        endcase
      end
      MODE_SP2: begin
        unique case (idx)
          IDX_UNITS:    g = 7'h24;
          IDX_TENS:     g = 7'h0C;
          IDX_HUNDREDS: g = 7'h12;
          default:      g = SEG_BLANK;
        endcase
      end
      MODE_REC: begin
        unique case (idx)
          IDX_UNITS:    g = 7'h46;
          IDX_TENS:     g = 7'h06;
          IDX_HUNDREDS: g = 7'h4E;
          default:      g = SEG_BLANK;
        endcase
      end
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/tdsm_digit_split.sv @@
// Saturates a load value to 999 and splits it into decimal digits.
module tdsm_digit_split (
  input  logic [tdsm_pkg::VALUE_W-1:0] value,
  output tdsm_pkg::digits_t            digits
);

  localparam int VW = tdsm_pkg::VALUE_W;
  localparam int DW = tdsm_pkg::DIGIT_W;
  localparam int RW = tdsm_pkg::REM_W;

  logic [VW-1:0] sat;
  logic [VW-1:0] hund_base;
  logic [DW-1:0] hund;
  logic [RW-1:0] rem;
  logic [RW-1:0] tens_base;
  logic [DW-1:0] tens;
  logic [RW-1:0] units_wide;

  // Compare against each hundred and each ten in parallel, then subtract
  always_comb begin
    sat = (value > tdsm_pkg::MAX_SHOWN) ? tdsm_pkg::MAX_SHOWN : value;
    hund      = '0;
    hund_base = '0;
    for (int k = 1; k < 10; k++) begin
      if (sat >= VW'(k * 100)) begin
        hund      = DW'(k);
        hund_base = VW'(k * 100);
      end
    end
    rem = RW'(sat - hund_base);
    tens      = '0;
    tens_base = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= RW'(k * 10)) begin
        tens      = DW'(k);
        tens_base = RW'(k * 10);
      end
    end
    units_wide = rem - tens_base;
  end

  assign digits.hundreds = hund;
  assign digits.tens     = tens;
  assign digits.units    = units_wide[DW-1:0];

endmodule

@@ hw/rtl/three_digit_seven_segment_mux_unit.sv @@
// Three-digit seven-segment display multiplexer: top level.
// A tick item's result appears in the output register in the cycle after the item is accepted.
// Throughput: one item per cycle while the output register is not held by m_tready; a load item gives no result.
// The input stays ready while the output register is empty or being drained.
// Reset (rst, synchronous, active high): position units, digits zero, numeric mode,
// output register empty.
module three_digit_seven_segment_mux_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tdsm_pkg::IN_DATA_W-1:0]     s_tdata,  // value[9:0], mode[11:10], zero pad
  input  logic                               s_tuser,  // kind: 0 tick, 1 load
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tdsm_pkg::OUT_DATA_W-1:0]    m_tdata   // segments[6:0], digit_enable[9:7], pad
);

  localparam int VW = tdsm_pkg::VALUE_W;
  localparam int MW = tdsm_pkg::MODE_W;
  localparam int SW = tdsm_pkg::SEG_W;
  localparam int EW = tdsm_pkg::EN_W;

  logic                        accept;
  logic [VW-1:0]               in_value;
  logic [MW-1:0]               in_mode;
  tdsm_pkg::digits_t           load_digits;
  tdsm_pkg::digits_t           digits;
  logic [MW-1:0]               shown_mode;
  logic [tdsm_pkg::POS_W-1:0]  position;
  logic [tdsm_pkg::POS_W-1:0]  position_next;
  logic [tdsm_pkg::IDX_W-1:0]  idx;
  logic [tdsm_pkg::DIGIT_W-1:0] cur_digit;
  logic [SW-1:0]               seg_next;
  logic [EW-1:0]               en_next;
  logic [SW-1:0]               seg_q;
  logic [EW-1:0]               en_q;

  // Unpack the input item
  assign in_value = s_tdata[VW-1:0];
  assign in_mode  = s_tdata[VW+MW-1:VW];

  // Take a new item whenever the output register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  tdsm_digit_split u_split (
    .value  (in_value),
    .digits (load_digits)
  );

  // Decode the position into a digit index and pick the next position
  always_comb begin
    unique case (position)
      tdsm_pkg::POS_TENS: begin
        idx           = tdsm_pkg::IDX_TENS;
        cur_digit     = digits.tens;
        position_next = tdsm_pkg::POS_HUNDREDS;
        en_next       = 3'b010;
      end
      tdsm_pkg::POS_HUNDREDS: begin
        idx           = tdsm_pkg::IDX_HUNDREDS;
        cur_digit     = digits.hundreds;
        position_next = tdsm_pkg::POS_UNITS;
        en_next       = 3'b100;
      end
      default: begin
        idx           = tdsm_pkg::IDX_UNITS;
        cur_digit     = digits.units;
        position_next = tdsm_pkg::POS_TENS;
        en_next       = 3'b001;
      end
    endcase
  end

  // Select the glyph for the current position
  assign seg_next = (shown_mode == tdsm_pkg::MODE_NUMERIC) ?
                    tdsm_pkg::digit_glyph(cur_digit) :
                    tdsm_pkg::word_glyph(shown_mode, idx);

  // Update display state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= tdsm_pkg::POS_UNITS;
      digits     <= '0;
      shown_mode <= tdsm_pkg::MODE_NUMERIC;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        if (s_tuser == tdsm_pkg::KIND_LOAD) begin
          digits     <= load_digits;
          shown_mode <= in_mode;
        end else begin
          position <= position_next;
          m_tvalid <= 1'b1;
        end
      end
    end
  end

  // Capture the result of a tick item
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == tdsm_pkg::KIND_TICK)) begin
      seg_q <= seg_next;
      en_q  <= en_next;
    end
  end

  assign m_tdata = {{(tdsm_pkg::OUT_DATA_W - SW - EW){1'b0}}, en_q, seg_q};

endmodule
